// File: rtl/mcnrc_pkg.sv
// Shared constants and types for the minimum-cost no-repeat coloring core.
`timescale 1ns / 1ps

package mcnrc_pkg;

  // Fixed field widths of the stream and configuration beats.
  localparam int unsigned COLOR_COUNT_W     = 6;
  localparam int unsigned COST_W            = 16;
  localparam int unsigned MIN_TOTAL_W       = 24;
  localparam int unsigned S_TDATA_W         = 16;
  localparam int unsigned M_TDATA_W         = 24;

  // Color count after reset.
  localparam logic [COLOR_COUNT_W-1:0] COLOR_COUNT_RESET = 6'd3;

  // Per-item control flags handed from the sequencer to the datapath.
  typedef struct packed {
    logic row_end;   // item is the last color of its row
    logic last;      // row end of the final row: emit the result and clear
  } item_ctl_t;

endpackage

// File: rtl/mcnrc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module mcnrc_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [WIDTH-1:0]      wdata_i,
  input  logic                  re_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [WIDTH-1:0]      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/mcnrc_dp.sv
// Datapath: row-total memory, forwarding, per-item total and best/second-best tracking.
`timescale 1ns / 1ps

module mcnrc_dp #(
  parameter int unsigned MAX_COLORS  = 32,
  parameter int unsigned TOTAL_WIDTH = 24,
  localparam int unsigned IDX_W = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         acc_i,
  input  logic [mcnrc_pkg::COST_W-1:0] cost_i,
  input  logic [IDX_W-1:0]             addr_i,
  input  mcnrc_pkg::item_ctl_t         ctl_i,
  input  logic                         out_free_i,
  output logic                         stage_ready_o,
  output logic                         res_valid_o,
  output logic [TOTAL_WIDTH-1:0]       res_total_o
);

  localparam int unsigned SUM_W =
    ((TOTAL_WIDTH > mcnrc_pkg::COST_W) ? TOTAL_WIDTH : mcnrc_pkg::COST_W) + 1;
  localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = {TOTAL_WIDTH{1'b1}};

  // Compute stage registers.
  logic                         s1_valid_q, s1_valid_d;
  logic [mcnrc_pkg::COST_W-1:0] s1_cost_q;
  logic [IDX_W-1:0]             s1_addr_q;
  mcnrc_pkg::item_ctl_t         s1_ctl_q;
  logic                         ent_valid_q;
  logic                         fwd_hit_q;
  logic                         fwd_zero_q;
  logic [TOTAL_WIDTH-1:0]       fwd_total_q;

  // Row state.
  logic [TOTAL_WIDTH-1:0] prev_best_q, prev_best_d;
  logic [TOTAL_WIDTH-1:0] prev_second_q, prev_second_d;
  logic [TOTAL_WIDTH-1:0] run_best_q, run_best_d;
  logic [TOTAL_WIDTH-1:0] run_second_q, run_second_d;
  logic [MAX_COLORS-1:0]  valid_q, valid_d;

  logic [TOTAL_WIDTH-1:0] rd_data;
  logic [TOTAL_WIDTH-1:0] own;
  logic [TOTAL_WIDTH-1:0] base;
  logic [SUM_W-1:0]       sum;
  logic [TOTAL_WIDTH-1:0] total;
  logic [TOTAL_WIDTH-1:0] new_best;
  logic [TOTAL_WIDTH-1:0] new_second;
  logic                   adv;

  mcnrc_ram #(
    .WIDTH (TOTAL_WIDTH),
    .DEPTH (MAX_COLORS)
  ) u_totals (
    .clk_i   (clk_i),
    .we_i    (adv),
    .waddr_i (s1_addr_q),
    .wdata_i (total),
    .re_i    (acc_i),
    .raddr_i (addr_i),
    .rdata_o (rd_data)
  );

  // A result can leave only when the output register has room.
  assign adv           = s1_valid_q && (!s1_ctl_q.last || out_free_i);
  assign stage_ready_o = !s1_valid_q || adv;
  assign res_valid_o   = adv && s1_ctl_q.last;

  always_comb begin
    if (fwd_zero_q) begin
      own = '0;
    end else if (fwd_hit_q) begin
      own = fwd_total_q;
    end else if (ent_valid_q) begin
      own = rd_data;
    end else begin
      own = '0;
    end

    base = (own == prev_best_q) ? prev_second_q : prev_best_q;
    sum  = SUM_W'(s1_cost_q) + SUM_W'(base);
    if (sum > SUM_W'(TOTAL_MAX)) begin
      total = TOTAL_MAX;
    end else begin
      total = sum[TOTAL_WIDTH-1:0];
    end

    if (total < run_best_q) begin
      new_best   = total;
      new_second = run_best_q;
    end else if (total < run_second_q) begin
      new_best   = run_best_q;
      new_second = total;
    end else begin
      new_best   = run_best_q;
      new_second = run_second_q;
    end
  end

  assign res_total_o = new_best;

  always_comb begin
    s1_valid_d    = s1_valid_q;
    prev_best_d   = prev_best_q;
    prev_second_d = prev_second_q;
    run_best_d    = run_best_q;
    run_second_d  = run_second_q;
    valid_d       = valid_q;
    if (adv) begin
      s1_valid_d = 1'b0;
      if (s1_ctl_q.last) begin
        prev_best_d   = '0;
        prev_second_d = '0;
        run_best_d    = TOTAL_MAX;
        run_second_d  = TOTAL_MAX;
        valid_d       = '0;
      end else begin
        valid_d[s1_addr_q] = 1'b1;
        if (s1_ctl_q.row_end) begin
          prev_best_d   = new_best;
          prev_second_d = new_second;
          run_best_d    = TOTAL_MAX;
          run_second_d  = TOTAL_MAX;
        end else begin
          run_best_d   = new_best;
          run_second_d = new_second;
        end
      end
    end
    if (acc_i) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      prev_best_q   <= '0;
      prev_second_q <= '0;
      run_best_q    <= TOTAL_MAX;
      run_second_q  <= TOTAL_MAX;
      valid_q       <= '0;
    end else begin
      s1_valid_q    <= s1_valid_d;
      prev_best_q   <= prev_best_d;
      prev_second_q <= prev_second_d;
      run_best_q    <= run_best_d;
      run_second_q  <= run_second_d;
      valid_q       <= valid_d;
    end
  end

  // The item ahead writes its total on the same edge this item reads the memory,
  // so its total and its clear are captured here and override the read data.
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_cost_q   <= cost_i;
      s1_addr_q   <= addr_i;
      s1_ctl_q    <= ctl_i;
      ent_valid_q <= valid_q[addr_i];
      fwd_hit_q   <= adv && (s1_addr_q == addr_i);
      fwd_zero_q  <= adv && s1_ctl_q.last;
      fwd_total_q <= total;
    end
  end

endmodule

// File: rtl/min_cost_no_repeat_coloring_core.sv
// Top level of the minimum-cost no-repeat coloring core.
`timescale 1ns / 1ps

// Streaming minimum-cost coloring (best/second-best dynamic program). Cost beats
// arrive row by row, color 0 first, one cost per color; the number of colors per
// row is the color_count register (zero acts as one, values above MAX_COLORS act
// as MAX_COLORS). Each color's total is its cost plus the previous row's best
// total, or the previous second best where that color's own previous total equals
// the best; totals saturate at 2^TOTAL_WIDTH-1. A beat whose tuser flag is set on
// the last color of a row ends the run: one output beat carries the least total
// and all row state is cleared. The core takes one cost beat per clock cycle
// unless a result stall holds it; that figure is set by the read-modify-write
// loop on the row-total memory, which reads on accept and writes back from the
// compute stage, with the write-back forwarded to the next beat. A result passes
// from the compute stage into an output register on the master side, so input
// beats keep flowing while it waits; input stalls only when a second result
// is ready before the first one was taken. Per-entry valid bits clear the memory
// at once, so there is no clearing pass after reset. Write color_count only while
// the core is idle; a write does not clear row state.
module min_cost_no_repeat_coloring_core #(
  parameter int unsigned MAX_COLORS  = 32,
  parameter int unsigned TOTAL_WIDTH = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Cost stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [mcnrc_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // [15:0] cost
  input  logic [0:0]                          s_axis_tuser,  // [0] final_row
  // Result stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [mcnrc_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // [23:0] min_total
  // Color count register write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mcnrc_pkg::COLOR_COUNT_W-1:0] cfg_data_i
);

  localparam int unsigned IDX_W = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
  localparam int unsigned CMP_W =
    (IDX_W + 1 > mcnrc_pkg::COLOR_COUNT_W + 1) ? IDX_W + 1 : mcnrc_pkg::COLOR_COUNT_W + 1;
  localparam int unsigned EXT_W =
    (TOTAL_WIDTH > mcnrc_pkg::MIN_TOTAL_W) ? TOTAL_WIDTH : mcnrc_pkg::MIN_TOTAL_W;

  logic [mcnrc_pkg::COLOR_COUNT_W-1:0] color_count_q, color_count_d;
  logic [IDX_W-1:0]                    color_index_q, color_index_d;
  logic                                out_valid_q, out_valid_d;
  logic [mcnrc_pkg::MIN_TOTAL_W-1:0]   out_data_q;

  logic [CMP_W-1:0]       eff_count;
  logic [CMP_W-1:0]       next_index;
  logic                   acc;
  logic                   stage_ready;
  logic                   res_valid;
  logic [TOTAL_WIDTH-1:0] res_total;
  logic [EXT_W-1:0]       res_ext;
  mcnrc_pkg::item_ctl_t   ctl;

  assign cfg_ready_o   = 1'b1;
  assign color_count_d = cfg_valid_i ? cfg_data_i : color_count_q;

  // Effective count is clamped into one to MAX_COLORS.
  always_comb begin
    if (color_count_q == '0) begin
      eff_count = CMP_W'(1);
    end else if (CMP_W'(color_count_q) > CMP_W'(MAX_COLORS)) begin
      eff_count = CMP_W'(MAX_COLORS);
    end else begin
      eff_count = CMP_W'(color_count_q);
    end
  end

  // The row end depends only on the color index and the color count, so it is decided on accept.
  assign acc         = s_axis_tvalid && s_axis_tready;
  assign next_index  = CMP_W'(color_index_q) + CMP_W'(1);
  assign ctl.row_end = (next_index >= eff_count);
  assign ctl.last    = ctl.row_end && s_axis_tuser[0];

  always_comb begin
    color_index_d = color_index_q;
    if (acc) begin
      color_index_d = ctl.row_end ? '0 : next_index[IDX_W-1:0];
    end
  end

  assign s_axis_tready = stage_ready;

  mcnrc_dp #(
    .MAX_COLORS  (MAX_COLORS),
    .TOTAL_WIDTH (TOTAL_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .acc_i         (acc),
    .cost_i        (s_axis_tdata[mcnrc_pkg::COST_W-1:0]),
    .addr_i        (color_index_q),
    .ctl_i         (ctl),
    .out_free_i    (!out_valid_q || m_axis_tready),
    .stage_ready_o (stage_ready),
    .res_valid_o   (res_valid),
    .res_total_o   (res_total)
  );

  // Result beat register; a new result is loaded only when the slot frees up.
  assign res_ext = EXT_W'(res_total);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_count_q <= mcnrc_pkg::COLOR_COUNT_RESET;
      color_index_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      color_count_q <= color_count_d;
      color_index_q <= color_index_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_data_q <= res_ext[mcnrc_pkg::MIN_TOTAL_W-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
